/* rtl/core/score_timed_led_fader_assert.svh */
// Assertion macros shared by the fader RTL.
`ifndef SCORE_TIMED_LED_FADER_ASSERT_SVH
`define SCORE_TIMED_LED_FADER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define STLF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define STLF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/core/stlf_pkg.sv */
// Package with types and constants for the score timed LED fader.
`timescale 1ns / 1ps
package stlf_pkg;
	localparam int ScoreDepth = 256;
	localparam int KeyCount   = 9;
	localparam int AddrW      = 8;
	localparam logic [31:0] LastEventMs = 32'd2535;
	localparam logic [7:0]  LevelMax    = 8'd255;
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic CFG_LENGTH = 1'b0;
	localparam logic CFG_MAP    = 1'b1;
	localparam logic [35:0] LedMapReset = 36'h876543210;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  entry_index;
		logic [31:0] entry_start_ms;
		logic [8:0]  entry_mask;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [3:0] led_number;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic       last_led;
	} out_item_t;
endpackage

/* rtl/core/stlf_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module stlf_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/stlf_div.sv */
// Restoring divider producing floor((elapsed << 16) / dur) for elapsed < dur.
`timescale 1ns / 1ps
module stlf_div import stlf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [16:0] quo
);
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [33:0] trial;

	// Remainder stays below den, so one shifted bit and compare per step.
	assign trial = {rem_q, 1'b0} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (run_q) begin
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], 1'b0};
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end
	assign quo = quo_q;
endmodule

/* rtl/core/score_timed_led_fader.sv */
// Top level of the score timed LED fader.
//
// Channel   Signals                          Handshake
// command   start, busy, in_item             beat taken when start && !busy
// config    cfg_we, cfg_index, cfg_data      written when cfg_we
// result    out_valid, out_item              each beat shown for one cycle, no back-pressure
//
// Writes and restarts are done on acceptance and leave busy low. A tick reads the
// current entry (ST_RDC, ST_CAPC), repeats those states with ST_RDN and ST_WALK for each
// event passed, and uses ST_RDN and ST_WALK to compare a following event; then ST_FRAC
// forms the fraction, with the serial divide when it is needed, followed by two multiply
// stages and nine beats on consecutive cycles. The last beat is on the ports in the first
// cycle after busy falls. The score memories are not cleared at reset; entries must be
// written before a tick reads them. The receiver cannot stall.
`timescale 1ns / 1ps
module score_timed_led_fader import stlf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    in_item,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [35:0] cfg_data,
	output logic        out_valid,
	output out_item_t   out_item
);
`include "score_timed_led_fader_assert.svh"

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDC  = 4'd1; // read current entry
	localparam logic [3:0] ST_WALK = 4'd2; // compare next start against now
	localparam logic [3:0] ST_RDN  = 4'd3; // wait for next-entry data
	localparam logic [3:0] ST_FRAC = 4'd4; // take the full fraction or start the divide
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_MUL1 = 4'd6;
	localparam logic [3:0] ST_MUL2 = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;
	localparam logic [3:0] ST_CAPC = 4'd9; // capture current entry data

	logic [3:0]  state_q;
	logic [8:0]  len_q;
	logic [35:0] map_q;
	logic [7:0]  cur_q;
	logic [31:0] now_q;
	logic [31:0] cur_start_q;
	logic [8:0]  cur_mask_q;
	logic [31:0] elapsed_q;
	logic [31:0] dur_q;
	logic        div_go_q;
	logic [16:0] f_q;
	logic [16:0] gain_q;
	logic [7:0]  fall_q;
	logic [7:0]  rise_q;
	logic [7:0]  gfall_q;
	logic [7:0]  grise_q;
	logic [8:0]  next_mask_q;
	logic [3:0]  key_q;

	logic [8:0]  len_eff;
	logic        has_next;
	logic [7:0]  raddr;
	logic [31:0] rd_start;
	logic [8:0]  rd_mask;
	logic        wr_en;
	logic        div_done;
	logic [16:0] div_quo;
	logic        accept;

	// An event length above the table depth behaves as the full depth.
	assign len_eff  = (len_q > 9'(ScoreDepth)) ? 9'(ScoreDepth) : len_q;
	assign has_next = ({1'b0, cur_q} + 9'd1) < len_eff;
	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign wr_en    = accept && in_item.cmd == CMD_WRITE;
	// The current entry is read from ST_RDC; otherwise the entry after it is addressed.
	assign raddr    = (state_q == ST_RDC) ? cur_q : cur_q + 8'd1;

	stlf_ram #(.Width(32), .Depth(ScoreDepth)) u_start_ram (
		.clk(clk), .we(wr_en), .waddr(in_item.entry_index),
		.wdata(in_item.entry_start_ms), .raddr(raddr), .rdata(rd_start)
	);
	stlf_ram #(.Width(9), .Depth(ScoreDepth)) u_mask_ram (
		.clk(clk), .we(wr_en), .waddr(in_item.entry_index),
		.wdata(in_item.entry_mask), .raddr(raddr), .rdata(rd_mask)
	);

	stlf_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .num(elapsed_q),
		.den(dur_q), .done(div_done), .quo(div_quo)
	);

	// Control: config writes and restarts; for a tick, index walk, then fraction, then nine result beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= 9'd1;
			map_q     <= LedMapReset;
			cur_q     <= '0;
			div_go_q  <= 1'b0;
			key_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			div_go_q  <= 1'b0;
			out_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_LENGTH) begin
					len_q <= cfg_data[8:0];
				end else begin
					map_q <= cfg_data;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_item.cmd == CMD_RESTART) begin
						cur_q <= '0;
					end else if (accept && in_item.cmd == CMD_TICK) begin
						state_q <= ST_RDC;
					end
				end
				ST_RDC: state_q <= ST_CAPC;
				ST_CAPC: state_q <= has_next ? ST_RDN : ST_FRAC;
				ST_RDN: state_q <= ST_WALK;
				ST_WALK: begin
					// Step past the next event once its start has been reached.
					if (now_q >= rd_start) begin
						cur_q   <= cur_q + 8'd1;
						state_q <= ST_RDC;
					end else begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (dur_q != '0 && elapsed_q < dur_q) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end else begin
						state_q  <= ST_MUL1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					state_q <= ST_EMIT;
					key_q   <= '0;
				end
				ST_EMIT: begin
					out_valid <= 1'b1;
					key_q     <= key_q + 4'd1;
					if (key_q == 4'(KeyCount - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_item.now_ms;
		end
		if (state_q == ST_CAPC) begin
			cur_start_q <= rd_start;
			cur_mask_q  <= rd_mask;
			elapsed_q   <= now_q - rd_start;
			dur_q       <= LastEventMs;
			next_mask_q <= '0;
		end
		if (state_q == ST_WALK && now_q < rd_start) begin
			dur_q       <= rd_start - cur_start_q;
			next_mask_q <= rd_mask;
		end
		if (state_q == ST_FRAC) begin
			f_q <= 17'h10000;
		end
		if (state_q == ST_DIV && div_done) begin
			f_q <= div_quo;
		end
		if (state_q == ST_MUL1) begin
			fall_q <= 8'(((34'(17'h10000 - f_q)) * 34'(LevelMax)) >> 16);
			rise_q <= 8'(((34'(f_q)) * 34'(LevelMax)) >> 16);
			gain_q <= 17'h10000 - 17'((34'(f_q) * 34'(17'h10000 - f_q)) >> 16);
		end
		if (state_q == ST_MUL2) begin
			gfall_q <= 8'((25'(fall_q) * 25'(gain_q)) >> 16);
			grise_q <= 8'((25'(rise_q) * 25'(gain_q)) >> 16);
		end
		if (state_q == ST_EMIT) begin
			out_item.led_number  <= map_q[4*key_q +: 4];
			out_item.green_level <= cur_mask_q[4'(KeyCount - 1) - key_q] ? gfall_q : 8'd0;
			out_item.blue_level  <= next_mask_q[4'(KeyCount - 1) - key_q] ? grise_q : 8'd0;
			out_item.last_led    <= (key_q == 4'(KeyCount - 1));
		end
	end

	`STLF_ASSERT_IMP(a_no_accept_busy, busy, !accept)
	`STLF_ASSERT_NEXT(a_tick_busy, accept && in_item.cmd == CMD_TICK, busy)
	`STLF_ASSERT_IMP(a_out_in_emit, out_valid, busy || out_item.last_led)
	`STLF_ASSERT_IMP(a_index_range, state_q == ST_WALK, has_next)
endmodule

/* dv/score_timed_led_fader_test.sv */
// Self-checking testbench for the score timed LED fader.
`timescale 1ns / 1ps
module score_timed_led_fader_test;
	import stlf_pkg::*;

	// The unused command code; the block must swallow it without results.
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int CycleLimit = 3000000;
	// Idle margin after the last beat before registers are touched.
	localparam int SettleCycles = 600;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    in_item;
	logic        cfg_we;
	logic        cfg_index;
	logic [35:0] cfg_data;
	logic        out_valid;
	out_item_t   out_item;

	score_timed_led_fader dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_item(out_item)
	);

	// Our own copy of the block's state and settings.
	logic [31:0] score_times [ScoreDepth];
	logic [8:0]  score_masks [ScoreDepth];
	logic [7:0]  event_pos;
	logic [8:0]  score_len;
	logic [35:0] led_map;

	in_item_t  cmd_q [$];
	out_item_t led_q [$];
	int        err_count;
	int        cycle_count;
	bit        beat_taken;
	bit        no_gaps;
	int        gap_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Works out the nine LED beats a tick at time now produces, updating the index.
	task automatic predict_leds(input logic [31:0] now);
		int          len;
		int          idx;
		bit          has_next;
		logic [8:0]  cur_mask;
		logic [8:0]  nxt_mask;
		logic [31:0] dur;
		logic [31:0] elapsed;
		logic [63:0] frac;
		logic [63:0] fall;
		logic [63:0] rise;
		logic [63:0] gain;
		logic [7:0]  g_lvl;
		logic [7:0]  b_lvl;
		bit          in_cur;
		bit          in_nxt;
		out_item_t   led;
		len = (score_len > ScoreDepth) ? ScoreDepth : int'(score_len);
		idx = int'(event_pos);
		while (idx + 1 < len && now >= score_times[idx + 1])
			idx++;
		event_pos = idx[7:0];
		has_next = (idx + 1 < len);
		cur_mask = score_masks[idx];
		nxt_mask = has_next ? score_masks[idx + 1] : 9'd0;
		dur = has_next ? score_times[idx + 1] - score_times[idx] : LastEventMs;
		elapsed = now - score_times[idx];
		if (dur == 0 || elapsed >= dur)
			frac = 64'd65536;
		else
			frac = ({32'd0, elapsed} << 16) / dur;
		fall = ((64'd65536 - frac) * LevelMax) >> 16;
		rise = (frac * LevelMax) >> 16;
		gain = 64'd65536 - ((frac * (64'd65536 - frac)) >> 16);
		for (int b = 0; b < KeyCount; b++) begin
			in_cur = cur_mask[KeyCount - 1 - b];
			in_nxt = nxt_mask[KeyCount - 1 - b];
			g_lvl = in_cur ? 8'((fall * gain) >> 16) : 8'd0;
			b_lvl = in_nxt ? 8'((rise * gain) >> 16) : 8'd0;
			led.led_number = led_map[4 * b +: 4];
			led.green_level = g_lvl;
			led.blue_level = b_lvl;
			led.last_led = (b == KeyCount - 1);
			led_q.push_back(led);
		end
	endtask

	task automatic apply_command(input in_item_t c);
		case (c.cmd)
			CMD_WRITE: begin
				score_times[c.entry_index] = c.entry_start_ms;
				score_masks[c.entry_index] = c.entry_mask;
			end
			CMD_RESTART: event_pos = 8'd0;
			CMD_TICK: predict_leds(c.now_ms);
			default: ;
		endcase
	endtask

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (no_gaps || r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Driver: a new beat is presented at the falling edge once the last one is taken.
	always @(negedge clk) begin
		if (arst_n && (!start || beat_taken)) begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				in_item <= cmd_q.pop_front();
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: commands are predicted as they are accepted, and results checked.
	always @(posedge clk) begin
		out_item_t exp_led;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("score_timed_led_fader_test: errors");
				$finish;
			end
			if (start && !busy) begin
				apply_command(in_item);
				beat_taken = 1'b1;
			end
			if (out_valid) begin
				if (led_q.size() == 0) begin
					$error("unexpected LED beat %p", out_item);
					err_count++;
				end else begin
					exp_led = led_q.pop_front();
					if (out_item.led_number !== exp_led.led_number) begin
						$error("led_number: expected %0d, got %0d",
							exp_led.led_number, out_item.led_number);
						err_count++;
					end
					if (out_item.green_level !== exp_led.green_level) begin
						$error("green_level: expected %0d, got %0d",
							exp_led.green_level, out_item.green_level);
						err_count++;
					end
					if (out_item.blue_level !== exp_led.blue_level) begin
						$error("blue_level: expected %0d, got %0d",
							exp_led.blue_level, out_item.blue_level);
						err_count++;
					end
					if (out_item.last_led !== exp_led.last_led) begin
						$error("last_led: expected %0b, got %0b",
							exp_led.last_led, out_item.last_led);
						err_count++;
					end
				end
			end
		end
	end

	function automatic in_item_t make_cmd(input logic [1:0] cmd, input logic [7:0] slot,
		input logic [31:0] t_start, input logic [8:0] mask, input logic [31:0] now);
		in_item_t c;
		c.cmd = cmd;
		c.entry_index = slot;
		c.entry_start_ms = t_start;
		c.entry_mask = mask;
		c.now_ms = now;
		return c;
	endfunction

	// Fields that a command does not use carry random values all the same.
	function automatic in_item_t write_cmd(input logic [7:0] slot, input logic [31:0] t_start,
		input logic [8:0] mask);
		return make_cmd(CMD_WRITE, slot, t_start, mask, 32'($urandom()));
	endfunction

	// The very top of the time range would pass the guard event, so random ticks stop short.
	function automatic in_item_t tick_cmd(input logic [31:0] now);
		return make_cmd(CMD_TICK, 8'($urandom()), 32'($urandom()), 9'($urandom()),
			(now == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : now);
	endfunction

	function automatic in_item_t stray_cmd(input logic [1:0] cmd);
		return make_cmd(cmd, 8'($urandom()), 32'($urandom()), 9'($urandom()),
			32'($urandom()));
	endfunction

	// Lays down a score of count events from t0 on; some events have no length at all.
	task automatic queue_score(input int count, input logic [31:0] t0, input int max_gap);
		logic [31:0] t;
		t = t0;
		for (int i = 0; i < count; i++) begin
			cmd_q.push_back(write_cmd(i[7:0], t, 9'($urandom())));
			t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_gap);
		end
	endtask

	// Waits for every queued beat to be taken and every LED beat to arrive.
	task automatic drain();
		wait (cmd_q.size() == 0 && !start && led_q.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Registers are only touched while the block is idle; the model follows at once.
	task automatic write_reg(input logic idx, input logic [35:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 36'($urandom());
		if (idx == CFG_LENGTH)
			score_len = value[8:0];
		else
			led_map = value;
	endtask

	// One phase: new settings, a tick on whatever index the last phase left, a fresh
	// score at the front of the table closed by a guard event at the end of time, and a
	// play-through with random time steps and a sprinkling of stray commands.
	task automatic run_phase(input logic [8:0] len, input logic [35:0] map, input int ticks);
		logic [31:0] base;
		logic [31:0] now;
		int          count;
		int          r;
		drain();
		write_reg(CFG_LENGTH, {27'd0, len});
		write_reg(CFG_MAP, map);
		no_gaps = ($urandom_range(0, 3) == 0);
		cmd_q.push_back(tick_cmd(32'($urandom())));
		base = $urandom();
		count = $urandom_range(2, 6);
		queue_score(count, base, 3000);
		cmd_q.push_back(write_cmd(8'(count), 32'hFFFF_FFFF, 9'($urandom())));
		cmd_q.push_back(stray_cmd(CMD_RESTART));
		now = base - $urandom_range(0, 200);
		for (int i = 0; i < ticks; i++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				cmd_q.push_back(tick_cmd(32'($urandom())));
			else if (r == 1)
				cmd_q.push_back(write_cmd(8'($urandom_range(0, count - 1)),
					32'($urandom()), 9'($urandom())));
			else if (r == 2)
				cmd_q.push_back(stray_cmd(CMD_NONE));
			else if (r == 3)
				cmd_q.push_back(stray_cmd(CMD_RESTART));
			else begin
				now += (r == 4) ? $urandom_range(2000, 9000) : $urandom_range(0, 700);
				cmd_q.push_back(tick_cmd(now));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_LENGTH;
		cfg_data = '0;
		err_count = 0;
		cycle_count = 0;
		beat_taken = 1'b0;
		no_gaps = 1'b0;
		gap_left = 0;
		event_pos = 8'd0;
		score_len = 9'd1;
		led_map = LedMapReset;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats: extreme slots, times and masks, the unused command,
		// a time before the first event, and a time at the very top of the range.
		write_reg(CFG_LENGTH, 36'd3);
		cmd_q.push_back(write_cmd(8'd255, 32'hFFFF_FFFF, 9'h1FF));
		cmd_q.push_back(write_cmd(8'd0, 32'd0, 9'h000));
		cmd_q.push_back(write_cmd(8'd1, 32'd100, 9'h155));
		cmd_q.push_back(write_cmd(8'd2, 32'd1100, 9'h0AA));
		cmd_q.push_back(write_cmd(8'd3, 32'hFFFF_FFFF, 9'h1FF));
		cmd_q.push_back(make_cmd(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF));
		cmd_q.push_back(make_cmd(CMD_RESTART, 8'h00, 32'd0, 9'd0, 32'd0));
		cmd_q.push_back(tick_cmd(32'd0));
		cmd_q.push_back(make_cmd(CMD_TICK, 8'h00, 32'd0, 9'd0, 32'hFFFF_FFFF));
		cmd_q.push_back(write_cmd(8'd0, 32'd100, 9'h1FF));
		cmd_q.push_back(make_cmd(CMD_RESTART, 8'h00, 32'd0, 9'd0, 32'd0));
		cmd_q.push_back(tick_cmd(32'd50));
		// Both events share a start time, then fades land on quarter and half way.
		cmd_q.push_back(tick_cmd(32'd100));
		cmd_q.push_back(tick_cmd(32'd350));
		cmd_q.push_back(tick_cmd(32'd600));
		cmd_q.push_back(tick_cmd(32'd1099));
		cmd_q.push_back(tick_cmd(32'd1100));

		// Only the first event counts, so the walk never moves and the tail length holds.
		run_phase(9'd1, LedMapReset, 12);
		// No events: the current entry stands in as the last event.
		run_phase(9'd0, 36'h0, 10);
		run_phase(9'd256, 36'hF_FFFF_FFFF, 12);
		// Lengths beyond the table act as the full table.
		run_phase(9'd300, 36'($urandom()) << 4 | 36'($urandom_range(0, 15)), 12);
		run_phase(9'd511, {4'($urandom()), 32'($urandom())}, 10);
		run_phase(9'd5, {4'($urandom()), 32'($urandom())}, 12);
		// A long length followed by a short one leaves a stale index for the first tick.
		run_phase(9'd24, {4'($urandom()), 32'($urandom())}, 12);
		run_phase(9'd3, {4'($urandom()), 32'($urandom())}, 10);
		run_phase(9'($urandom_range(2, 40)), {4'($urandom()), 32'($urandom())}, 12);

		drain();
		if (err_count == 0)
			$display("score_timed_led_fader_test: clean");
		else
			$display("score_timed_led_fader_test: errors");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/stlf_pkg.sv
rtl/core/stlf_ram.sv
rtl/core/stlf_div.sv
rtl/core/score_timed_led_fader.sv
dv/score_timed_led_fader_test.sv
